// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the sequencer modules.
// Each check samples on the rising clock edge and is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every sampled edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property check failed");

// The expression must never be true at a sampled edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  // Request codes.
  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_CURSOR = 2'd1;
  localparam logic [1:0] REQ_WINDOW = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Panel command bytes used by cursor and window requests.
  localparam logic [7:0] CMD_COL   = 8'h2A;
  localparam logic [7:0] CMD_ROW   = 8'h2B;
  localparam logic [7:0] CMD_MEMWR = 8'h2C;

  // Sequence sizes in bytes, with the number of byte pairs each one takes.
  localparam int INIT_BYTES  = 71;
  localparam int INIT_PAIRS  = (INIT_BYTES + 1) / 2;
  localparam int COORD_BYTES = 11;
  localparam int COORD_PAIRS = (COORD_BYTES + 1) / 2;
  localparam int PAIR_W      = $clog2(INIT_PAIRS);
  localparam int INIT_IDX_W  = $clog2(INIT_BYTES + 1);
  localparam int COORD_IDX_W = $clog2(COORD_BYTES + 1);

  // One byte on the wire with its data/command flag.
  typedef struct packed {
    logic       dc;
    logic [7:0] value;
  } lcd_byte_t;

  // Controller state.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lcs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              emit;
    logic              last;
    logic              is_init;
    logic [PAIR_W-1:0] pair_idx;
  } ctrl_cmd_t;

  // Flattened init sequence; a byte past the end reads as zero.
  function automatic lcd_byte_t init_rom(input logic [INIT_IDX_W-1:0] idx);
    lcd_byte_t entry;
    case (idx)
      7'd0:  entry = 9'h036;
      7'd1:  entry = 9'h100;
      7'd2:  entry = 9'h03A;
      7'd3:  entry = 9'h105;
      7'd4:  entry = 9'h021;
      7'd5:  entry = 9'h02A;
      7'd6:  entry = 9'h100;
      7'd7:  entry = 9'h100;
      7'd8:  entry = 9'h101;
      7'd9:  entry = 9'h13F;
      7'd10: entry = 9'h02B;
      7'd11: entry = 9'h100;
      7'd12: entry = 9'h100;
      7'd13: entry = 9'h100;
      7'd14: entry = 9'h1EF;
      7'd15: entry = 9'h0B2;
      7'd16: entry = 9'h10C;
      7'd17: entry = 9'h10C;
      7'd18: entry = 9'h100;
      7'd19: entry = 9'h133;
      7'd20: entry = 9'h133;
      7'd21: entry = 9'h0B7;
      7'd22: entry = 9'h135;
      7'd23: entry = 9'h0BB;
      7'd24: entry = 9'h11F;
      7'd25: entry = 9'h0C0;
      7'd26: entry = 9'h12C;
      7'd27: entry = 9'h0C2;
      7'd28: entry = 9'h101;
      7'd29: entry = 9'h0C3;
      7'd30: entry = 9'h112;
      7'd31: entry = 9'h0C4;
      7'd32: entry = 9'h120;
      7'd33: entry = 9'h0C6;
      7'd34: entry = 9'h10F;
      7'd35: entry = 9'h0D0;
      7'd36: entry = 9'h1A4;
      7'd37: entry = 9'h1A1;
      7'd38: entry = 9'h0E0;
      7'd39: entry = 9'h1D0;
      7'd40: entry = 9'h108;
      7'd41: entry = 9'h111;
      7'd42: entry = 9'h108;
      7'd43: entry = 9'h10C;
      7'd44: entry = 9'h115;
      7'd45: entry = 9'h139;
      7'd46: entry = 9'h133;
      7'd47: entry = 9'h150;
      7'd48: entry = 9'h136;
      7'd49: entry = 9'h113;
      7'd50: entry = 9'h114;
      7'd51: entry = 9'h129;
      7'd52: entry = 9'h12D;
      7'd53: entry = 9'h0E1;
      7'd54: entry = 9'h1D0;
      7'd55: entry = 9'h108;
      7'd56: entry = 9'h110;
      7'd57: entry = 9'h108;
      7'd58: entry = 9'h106;
      7'd59: entry = 9'h106;
      7'd60: entry = 9'h139;
      7'd61: entry = 9'h144;
      7'd62: entry = 9'h151;
      7'd63: entry = 9'h10B;
      7'd64: entry = 9'h116;
      7'd65: entry = 9'h114;
      7'd66: entry = 9'h12F;
      7'd67: entry = 9'h131;
      7'd68: entry = 9'h021;
      7'd69: entry = 9'h011;
      7'd70: entry = 9'h029;
      default: entry = 9'h000;
    endcase
    return entry;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lcs_ctrl
  import lcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] req_type,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  lcs_state_t        state;
  lcs_state_t        state_next;
  logic [PAIR_W-1:0] pair_idx;
  logic [PAIR_W-1:0] pair_idx_next;
  logic              is_init;
  logic              is_init_next;
  logic              accept;
  logic              last;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // Final pair of the running request.
  assign last = is_init ? (pair_idx == PAIR_W'(INIT_PAIRS - 1))
                        : (pair_idx == PAIR_W'(COORD_PAIRS - 1));

  // State and pair counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pair_idx <= '0;
      is_init  <= 1'b0;
    end else begin
      state    <= state_next;
      pair_idx <= pair_idx_next;
      is_init  <= is_init_next;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_next    = state;
    pair_idx_next = pair_idx;
    is_init_next  = is_init;
    cmd           = '0;
    cmd.pair_idx  = pair_idx;
    cmd.is_init   = is_init;
    cmd.last      = last;
    case (state)
      ST_IDLE: begin
        if (accept && (req_type != REQ_NONE)) begin
          cmd.load      = 1'b1;
          state_next    = ST_RUN;
          pair_idx_next = '0;
          is_init_next  = (req_type == REQ_INIT);
        end
      end
      ST_RUN: begin
        cmd.emit = 1'b1;
        if (last) begin
          state_next = ST_IDLE;
        end else begin
          pair_idx_next = pair_idx + PAIR_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The final pair of a request always returns the controller to idle.
  `ASSERT_PROP(a_last_goes_idle, clk, rst, cmd.emit && cmd.last |=> state == ST_IDLE)
  // Cursor and window requests never count past their six pairs.
  `ASSERT_NEVER(a_coord_range, clk, rst, busy && !is_init && pair_idx > PAIR_W'(COORD_PAIRS - 1))
  // An unknown request is dropped without starting a sequence.
  `ASSERT_PROP(a_none_ignored, clk, rst, accept && req_type == REQ_NONE |=> state == ST_IDLE)

endmodule

`default_nettype wire

// ===== hw/rtl/lcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lcs_datapath
  import lcs_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] x_start,
  input  wire logic [15:0] y_start,
  input  wire logic [15:0] x_end,
  input  wire logic [15:0] y_end,
  output logic             strobe,
  output logic [7:0]       first_byte,
  output logic             first_is_data,
  output logic [7:0]       second_byte,
  output logic             second_is_data,
  output logic             second_valid,
  output logic             last_pair
);

  logic [COORD_WIDTH-1:0] xs;
  logic [COORD_WIDTH-1:0] xe;
  logic [COORD_WIDTH-1:0] ys;
  logic [COORD_WIDTH-1:0] ye;
  logic [15:0]            xs_w;
  logic [15:0]            xe_w;
  logic [15:0]            ys_w;
  logic [15:0]            ye_w;
  logic [INIT_IDX_W-1:0]  idx_a;
  logic [INIT_IDX_W-1:0]  idx_b;
  lcd_byte_t              byte_a;
  lcd_byte_t              byte_b;
  logic                   two;

  // Coordinates zero-extended to the 16-bit wire format.
  assign xs_w = 16'(xs);
  assign xe_w = 16'(xe);
  assign ys_w = 16'(ys);
  assign ye_w = 16'(ye);

  function automatic lcd_byte_t coord_byte(input logic [COORD_IDX_W-1:0] idx,
                                           input logic [15:0] a0,
                                           input logic [15:0] a1,
                                           input logic [15:0] b0,
                                           input logic [15:0] b1);
    lcd_byte_t entry;
    case (idx)
      4'd0:    entry = {1'b0, CMD_COL};
      4'd1:    entry = {1'b1, a0[15:8]};
      4'd2:    entry = {1'b1, a0[7:0]};
      4'd3:    entry = {1'b1, a1[15:8]};
      4'd4:    entry = {1'b1, a1[7:0]};
      4'd5:    entry = {1'b0, CMD_ROW};
      4'd6:    entry = {1'b1, b0[15:8]};
      4'd7:    entry = {1'b1, b0[7:0]};
      4'd8:    entry = {1'b1, b1[15:8]};
      4'd9:    entry = {1'b1, b1[7:0]};
      4'd10:   entry = {1'b0, CMD_MEMWR};
      default: entry = 9'h000;
    endcase
    return entry;
  endfunction

  // Capture coordinates; the window end becomes inclusive with wrap.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs <= x_start[COORD_WIDTH-1:0];
      ys <= y_start[COORD_WIDTH-1:0];
      if (req_type == REQ_WINDOW) begin
        xe <= x_end[COORD_WIDTH-1:0] - COORD_WIDTH'(1);
        ye <= y_end[COORD_WIDTH-1:0] - COORD_WIDTH'(1);
      end else begin
        xe <= x_start[COORD_WIDTH-1:0];
        ye <= y_start[COORD_WIDTH-1:0];
      end
    end
  end

  // Byte indexes of the current pair.
  assign idx_a = {cmd.pair_idx, 1'b0};
  assign idx_b = {cmd.pair_idx, 1'b1};

  // Select the pair from the init table or the coordinate sequence.
  always_comb begin
    if (cmd.is_init) begin
      byte_a = init_rom(idx_a);
      byte_b = init_rom(idx_b);
      two    = (idx_b < INIT_IDX_W'(INIT_BYTES));
    end else begin
      byte_a = coord_byte(idx_a[COORD_IDX_W-1:0], xs_w, xe_w, ys_w, ye_w);
      byte_b = coord_byte(idx_b[COORD_IDX_W-1:0], xs_w, xe_w, ys_w, ye_w);
      two    = (idx_b < INIT_IDX_W'(COORD_BYTES));
    end
  end

  // Output register: one beat per emitted pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      first_byte     <= byte_a.value;
      first_is_data  <= byte_a.dc;
      second_byte    <= two ? byte_b.value : 8'h00;
      second_is_data <= two && byte_b.dc;
      second_valid   <= two;
      last_pair      <= cmd.last;
    end
  end

  // A lone trailing byte only ever appears on the final beat.
  `ASSERT_PROP(a_lone_is_last, clk, rst, strobe && !second_valid |-> last_pair)
  // After the final beat of a request the strobe drops low before any further beat.
  `ASSERT_PROP(a_gap_after_last, clk, rst, strobe && last_pair |=> !strobe)

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_command_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The edge that takes start loads the controller state; the first result beat then leaves through the output register.
// Throughput: one pair per cycle from the controller's pair counter; init gives
// 36 beats, cursor and window 6, and the controller passes through idle before
// it takes the next request. Code 3 is taken and produces no beats.
// Results cannot be stalled.
// Reset (rst, synchronous) clears the controller and the result strobe only.

module lcd_command_sequencer
  import lcs_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] x_start,
  input  wire logic [15:0] y_start,
  input  wire logic [15:0] x_end,
  input  wire logic [15:0] y_end,
  output logic             strobe,
  output logic [7:0]       first_byte,
  output logic             first_is_data,
  output logic [7:0]       second_byte,
  output logic             second_is_data,
  output logic             second_valid,
  output logic             last_pair
);

  ctrl_cmd_t cmd;

  // Sequencing controller.
  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Byte selection and result register.
  lcs_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req_type),
    .x_start        (x_start),
    .y_start        (y_start),
    .x_end          (x_end),
    .y_end          (y_end),
    .strobe         (strobe),
    .first_byte     (first_byte),
    .first_is_data  (first_is_data),
    .second_byte    (second_byte),
    .second_is_data (second_is_data),
    .second_valid   (second_valid),
    .last_pair      (last_pair)
  );

endmodule

`default_nettype wire
